FILE: design/luhn_pkg.sv
// ----------------------------------------------------------------------------
// luhn_pkg
// Shared widths, codes, types and digit helpers for the Luhn card check.
// ----------------------------------------------------------------------------
package luhn_pkg;

   localparam int IN_WIDTH      = 63;
   localparam int BITS_PER_STEP = 3;
   localparam int CONV_STEPS    = IN_WIDTH / BITS_PER_STEP;
   localparam int STEP_WIDTH    = $clog2(CONV_STEPS);
   localparam int BCD_DIGITS    = 19;
   localparam int BCD_WIDTH     = 4 * BCD_DIGITS;
   localparam int MAX_DIGITS    = 19;
   localparam int COUNT_WIDTH   = 5;

   localparam logic [COUNT_WIDTH-1:0] LEN_13 = 5'd13;
   localparam logic [COUNT_WIDTH-1:0] LEN_15 = 5'd15;
   localparam logic [COUNT_WIDTH-1:0] LEN_16 = 5'd16;

   localparam logic [3:0] PREFIX_A_TENS     = 4'd3;
   localparam logic [3:0] PREFIX_A_ONES_LO  = 4'd4;
   localparam logic [3:0] PREFIX_A_ONES_HI  = 4'd7;
   localparam logic [3:0] PREFIX_B_TENS     = 4'd5;
   localparam logic [3:0] PREFIX_B_ONES_MIN = 4'd1;
   localparam logic [3:0] PREFIX_B_ONES_MAX = 4'd5;
   localparam logic [3:0] PREFIX_C_TENS     = 4'd4;

   localparam logic [1:0] BRAND_NONE = 2'd0;
   localparam logic [1:0] BRAND_A    = 2'd1;
   localparam logic [1:0] BRAND_B    = 2'd2;
   localparam logic [1:0] BRAND_C    = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } status_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] digit_count;
      logic                   length_ok;
      logic                   checksum_ok;
      logic [1:0]             brand;
   } result_type;

   // One shift-and-adjust step of binary to BCD conversion.
   function automatic logic [BCD_WIDTH-1:0] dabble_step(input logic [BCD_WIDTH-1:0] bcd,
                                                        input logic bit_in);
      logic [BCD_WIDTH-1:0] adj;
      adj = bcd;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (adj[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
         end
      end
      return {adj[BCD_WIDTH-2:0], bit_in};
   endfunction

   // Doubled digit, folded back to one digit when it passes nine.
   function automatic logic [3:0] luhn_double(input logic [3:0] d);
      logic [4:0] dbl;
      dbl = {d, 1'b0};
      if (dbl > 5'd9) begin
         return 4'(dbl - 5'd9);
      end
      return dbl[3:0];
   endfunction

endpackage

FILE: design/luhn_card_number_check.sv
// ----------------------------------------------------------------------------
// luhn_card_number_check
// Luhn mod 10 card number check with digit count, length and brand code.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  req     | in        | req_valid / req_ready | req_card_number[62:0]
//  rsp     | out       | rsp_valid / rsp_ready | rsp_digit_count[4:0], rsp_length_ok,
//          |           |                       | rsp_checksum_ok, rsp_brand[1:0]
//
//  Flow: an accepted request passes through the binary to BCD converter (3 bits a
//  cycle over 63 bits), then the digit scan (one digit a cycle), then rsp_valid.
//  Reset: synchronous, active high; clears the sequencer and all valid flags.
//  Stalls: a new request is taken while a finished response waits on rsp_ready;
//  a second result that finds the output register full holds in the scanner.
// ----------------------------------------------------------------------------
module luhn_card_number_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [luhn_pkg::IN_WIDTH-1:0]        req_card_number,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [luhn_pkg::COUNT_WIDTH-1:0]     rsp_digit_count,
   output logic                                 rsp_length_ok,
   output logic                                 rsp_checksum_ok,
   output logic [1:0]                           rsp_brand
);

   // sequencer codes
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CONV = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_HOLD = 2'd3;

   logic [1:0]                           state_ff, state_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   luhn_pkg::result_type                 rsp_ff, rsp_in;

   logic                                 req_take;
   logic                                 out_free;
   logic                                 scan_start;
   logic [luhn_pkg::BCD_WIDTH-1:0]       bcd;
   luhn_pkg::status_type                 conv_status;
   luhn_pkg::status_type                 scan_status;
   luhn_pkg::result_type                 scan_result;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_take   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   // converter done means its BCD register is final: start the scan off it
   assign scan_start = conv_status.done;

   luhn_bcd_conv u_conv (
      .clock       (clock),
      .reset       (reset),
      .start       (req_take),
      .card_number (req_card_number),
      .bcd         (bcd),
      .status      (conv_status)
   );

   luhn_digit_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (scan_start),
      .bcd    (bcd),
      .result (scan_result),
      .status (scan_status)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      // drop the response once it is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            if (conv_status.done) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_status.done) begin
               if (out_free) begin
                  rsp_in       = scan_result;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_HOLD;
               end
            end
         end
         S_HOLD: begin
            // scanner registers hold the result until the next start
            if (out_free) begin
               rsp_in       = scan_result;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digit_count = rsp_ff.digit_count;
   assign rsp_length_ok   = rsp_ff.length_ok;
   assign rsp_checksum_ok = rsp_ff.checksum_ok;
   assign rsp_brand       = rsp_ff.brand;

`ifndef SYNTHESIS
   a_take_when_units_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (!conv_status.busy && !scan_status.busy))
      else $error("request taken while a unit is busy");

   a_conv_done_starts_scan: assert property (@(posedge clock) disable iff (reset)
      conv_status.done |=> (scan_status.busy && state_ff == S_SCAN))
      else $error("scan did not start after conversion");

   a_scan_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_status.done |-> (state_ff == S_SCAN))
      else $error("scan finished outside the scan state");

   a_hold_needs_full_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD) |-> rsp_valid_ff)
      else $error("holding a result with an empty output register");
`endif

endmodule

FILE: design/luhn_bcd_conv.sv
// ----------------------------------------------------------------------------
// luhn_bcd_conv
// Iterative binary to BCD converter, several input bits per cycle.
// ----------------------------------------------------------------------------
module luhn_bcd_conv (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [luhn_pkg::IN_WIDTH-1:0]        card_number,
   output logic [luhn_pkg::BCD_WIDTH-1:0]       bcd,
   output luhn_pkg::status_type                 status
);

   logic                                 active_ff, active_in;
   logic                                 done_ff, done_in;
   logic [luhn_pkg::STEP_WIDTH-1:0]      step_ff, step_in;
   logic [luhn_pkg::IN_WIDTH-1:0]        bin_ff, bin_in;
   logic [luhn_pkg::BCD_WIDTH-1:0]       bcd_ff, bcd_in;
   logic                                 last_step;

   assign last_step = (step_ff == luhn_pkg::STEP_WIDTH'(luhn_pkg::CONV_STEPS - 1));

   always_comb begin
      logic [luhn_pkg::BCD_WIDTH-1:0] acc;
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      acc       = bcd_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         bin_in    = card_number;
         bcd_in    = '0;
      end else if (active_ff) begin
         // shift in the top bits, most significant first
         for (int k = 0; k < luhn_pkg::BITS_PER_STEP; k++) begin
            acc = luhn_pkg::dabble_step(acc, bin_ff[luhn_pkg::IN_WIDTH-1-k]);
         end
         bcd_in  = acc;
         bin_in  = bin_ff << luhn_pkg::BITS_PER_STEP;
         step_in = step_ff + 1'b1;
         if (last_step) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign bcd         = bcd_ff;
   assign status.busy = active_ff;
   assign status.done = done_ff;

endmodule

FILE: design/luhn_digit_scan.sv
// ----------------------------------------------------------------------------
// luhn_digit_scan
// Walks BCD digits from the low end: count, Luhn sum mod 10, leading digits.
// ----------------------------------------------------------------------------
module luhn_digit_scan (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [luhn_pkg::BCD_WIDTH-1:0]       bcd,
   output luhn_pkg::result_type                 result,
   output luhn_pkg::status_type                 status
);

   logic                                 active_ff, active_in;
   logic [luhn_pkg::BCD_WIDTH-1:0]       rest_ff, rest_in;
   logic [luhn_pkg::COUNT_WIDTH-1:0]     count_ff, count_in;
   logic [3:0]                           sum_ff, sum_in;
   logic [3:0]                           tens_ff, tens_in;
   logic [3:0]                           ones_ff, ones_in;
   logic                                 stop;
   logic                                 too_long;
   logic                                 len_hit;
   logic                                 luhn_ok;
   logic [3:0]                           digit;
   logic [3:0]                           term;
   logic [4:0]                           sum_raw;

   assign stop  = (rest_ff == '0) ||
                  (count_ff == luhn_pkg::COUNT_WIDTH'(luhn_pkg::MAX_DIGITS));
   assign digit = rest_ff[3:0];
   // the incoming digit is at an even position when the current count is odd
   assign term    = count_ff[0] ? luhn_pkg::luhn_double(digit) : digit;
   assign sum_raw = {1'b0, sum_ff} + {1'b0, term};

   always_comb begin
      active_in = active_ff;
      rest_in   = rest_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      tens_in   = tens_ff;
      ones_in   = ones_ff;
      if (start) begin
         active_in = 1'b1;
         rest_in   = bcd;
         count_in  = '0;
         sum_in    = '0;
         tens_in   = '0;
         ones_in   = '0;
      end else if (active_ff) begin
         if (stop) begin
            active_in = 1'b0;
         end else begin
            count_in = count_ff + 1'b1;
            sum_in   = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
            tens_in  = digit;
            ones_in  = tens_ff;
            rest_in  = rest_ff >> 4;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      rest_ff  <= rest_in;
      count_ff <= count_in;
      sum_ff   <= sum_in;
      tens_ff  <= tens_in;
      ones_ff  <= ones_in;
   end

   assign too_long = (rest_ff != '0);
   assign luhn_ok  = (sum_ff == 4'd0);
   assign len_hit  = (count_ff == luhn_pkg::LEN_13) || (count_ff == luhn_pkg::LEN_15) ||
                     (count_ff == luhn_pkg::LEN_16);

   always_comb begin
      result.digit_count = count_ff;
      result.length_ok   = !too_long && len_hit;
      result.checksum_ok = luhn_ok;
      result.brand       = luhn_pkg::BRAND_NONE;
      if (!too_long && luhn_ok) begin
         if ((tens_ff == luhn_pkg::PREFIX_A_TENS) &&
             ((ones_ff == luhn_pkg::PREFIX_A_ONES_LO) ||
              (ones_ff == luhn_pkg::PREFIX_A_ONES_HI)) &&
             (count_ff == luhn_pkg::LEN_15)) begin
            result.brand = luhn_pkg::BRAND_A;
         end else if ((tens_ff == luhn_pkg::PREFIX_B_TENS) &&
                      (ones_ff >= luhn_pkg::PREFIX_B_ONES_MIN) &&
                      (ones_ff <= luhn_pkg::PREFIX_B_ONES_MAX) &&
                      (count_ff == luhn_pkg::LEN_16)) begin
            result.brand = luhn_pkg::BRAND_B;
         end else if ((tens_ff == luhn_pkg::PREFIX_C_TENS) &&
                      ((count_ff == luhn_pkg::LEN_13) ||
                       (count_ff == luhn_pkg::LEN_16))) begin
            result.brand = luhn_pkg::BRAND_C;
         end
      end
   end

   assign status.busy = active_ff;
   assign status.done = active_ff && stop;

endmodule

FILE: bench/luhn_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// luhn_result_checker
// Watches both channels of the Luhn card check, predicts each verdict from
// the accepted card number and compares it with the response, field by field.
// ----------------------------------------------------------------------------
module luhn_result_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [luhn_pkg::IN_WIDTH-1:0]   req_card_number,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [luhn_pkg::COUNT_WIDTH-1:0] rsp_digit_count,
   input  logic                            rsp_length_ok,
   input  logic                            rsp_checksum_ok,
   input  logic [1:0]                      rsp_brand,
   output int                              error_count,
   output int                              pending_count
);

   localparam int DECIMAL_BASE   = 10;
   localparam int PREFIX_LIMIT   = 100;
   localparam int PREFIX_A_FIRST = 34;
   localparam int PREFIX_A_OTHER = 37;
   localparam int PREFIX_B_MIN   = 51;
   localparam int PREFIX_B_MAX   = 55;
   localparam int PREFIX_C_LEAD  = 4;

   luhn_pkg::result_type expected_verdicts [$];
   int                   mismatches = 0;

   function automatic luhn_pkg::result_type predict_luhn(
         input logic [luhn_pkg::IN_WIDTH-1:0] number);
      luhn_pkg::result_type verdict;
      logic [63:0] rest;
      logic [63:0] lead;
      int          count;
      int          sum;
      int          d;
      logic        too_long;
      rest  = {1'b0, number};
      count = 0;
      sum   = 0;
      while (rest != 0 && count < luhn_pkg::MAX_DIGITS) begin
         d = int'(rest % 64'(DECIMAL_BASE));
         count++;
         // every second digit from the right is doubled and folded
         if (count % 2 == 0) begin
            d = d * 2;
            if (d > DECIMAL_BASE - 1) begin
               d = d - (DECIMAL_BASE - 1);
            end
         end
         sum  = sum + d;
         rest = rest / 64'(DECIMAL_BASE);
      end
      too_long = (rest != 0);
      lead = {1'b0, number};
      while (lead >= 64'(PREFIX_LIMIT)) begin
         lead = lead / 64'(DECIMAL_BASE);
      end
      verdict.digit_count = luhn_pkg::COUNT_WIDTH'(count);
      verdict.checksum_ok = (sum % DECIMAL_BASE) == 0;
      verdict.length_ok   = !too_long && (verdict.digit_count == luhn_pkg::LEN_13 ||
                            verdict.digit_count == luhn_pkg::LEN_15 ||
                            verdict.digit_count == luhn_pkg::LEN_16);
      verdict.brand       = luhn_pkg::BRAND_NONE;
      if (!too_long && verdict.checksum_ok) begin
         if ((lead == 64'(PREFIX_A_FIRST) || lead == 64'(PREFIX_A_OTHER)) &&
             verdict.digit_count == luhn_pkg::LEN_15) begin
            verdict.brand = luhn_pkg::BRAND_A;
         end else if (lead >= 64'(PREFIX_B_MIN) && lead <= 64'(PREFIX_B_MAX) &&
                      verdict.digit_count == luhn_pkg::LEN_16) begin
            verdict.brand = luhn_pkg::BRAND_B;
         end else if (lead / 64'(DECIMAL_BASE) == 64'(PREFIX_C_LEAD) &&
                      (verdict.digit_count == luhn_pkg::LEN_13 ||
                       verdict.digit_count == luhn_pkg::LEN_16)) begin
            verdict.brand = luhn_pkg::BRAND_C;
         end
      end
      return verdict;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      luhn_pkg::result_type want;
      if (reset) begin
         expected_verdicts.delete();
      end else begin
         if (req_valid && req_ready) begin
            expected_verdicts.push_back(predict_luhn(req_card_number));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("response with no card number outstanding");
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_digit_count != want.digit_count)
                  report_mismatch($sformatf("digit_count got %0d want %0d",
                                            rsp_digit_count, want.digit_count));
               if (rsp_length_ok != want.length_ok)
                  report_mismatch($sformatf("length_ok got %0b want %0b",
                                            rsp_length_ok, want.length_ok));
               if (rsp_checksum_ok != want.checksum_ok)
                  report_mismatch($sformatf("checksum_ok got %0b want %0b",
                                            rsp_checksum_ok, want.checksum_ok));
               if (rsp_brand != want.brand)
                  report_mismatch($sformatf("brand got %0d want %0d",
                                            rsp_brand, want.brand));
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_verdicts.size();
   end

endmodule

FILE: bench/tb_luhn_card_number_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_luhn_card_number_check
// Drives card numbers into the Luhn check under several idle and stall
// patterns, with a directed set of prefixes and lengths followed by mostly
// well-formed random numbers; a side checker predicts and compares verdicts.
// ----------------------------------------------------------------------------
module tb_luhn_card_number_check;

   localparam int QUIET_LIMIT     = 5000;  // cycles without any transaction
   localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
   localparam int HOLD_ITEMS      = 20;
   localparam int PHASE_ITEMS     = 126;
   localparam int TAIL_CYCLES     = 60;    // longer than the worst transaction latency
   localparam int MAX_GAP         = 20;
   localparam int DECIMAL_BASE    = 10;
   localparam int PREFIX_A_FIRST  = 34;
   localparam int PREFIX_A_OTHER  = 37;
   localparam int PREFIX_B_MIN    = 51;
   localparam int PREFIX_B_MAX    = 55;
   localparam int PREFIX_C_LEAD   = 4;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [luhn_pkg::IN_WIDTH-1:0]    req_card_number = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [luhn_pkg::COUNT_WIDTH-1:0] rsp_digit_count;
   logic                             rsp_length_ok;
   logic                             rsp_checksum_ok;
   logic [1:0]                       rsp_brand;

   int error_count;
   int pending_count;

   // idle settings for the current phase, in percent of cycles
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   // bump to ask the receiver process for one long hold-off
   int hold_request_id = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   luhn_card_number_check dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_card_number (req_card_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digit_count (rsp_digit_count),
      .rsp_length_ok   (rsp_length_ok),
      .rsp_checksum_ok (rsp_checksum_ok),
      .rsp_brand       (rsp_brand)
   );

   luhn_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_card_number (req_card_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digit_count (rsp_digit_count),
      .rsp_length_ok   (rsp_length_ok),
      .rsp_checksum_ok (rsp_checksum_ok),
      .rsp_brand       (rsp_brand),
      .error_count     (error_count),
      .pending_count   (pending_count)
   );

   // Luhn sum modulo ten, only used to build numbers with a chosen check digit.
   function automatic int luhn_residue(input logic [63:0] number);
      int sum;
      int pos;
      int d;
      sum = 0;
      pos = 0;
      while (number != 0) begin
         d = int'(number % 64'(DECIMAL_BASE));
         pos++;
         if (pos % 2 == 0) begin
            d = d * 2;
            if (d > DECIMAL_BASE - 1) d = d - (DECIMAL_BASE - 1);
         end
         sum    = sum + d;
         number = number / 64'(DECIMAL_BASE);
      end
      return sum % DECIMAL_BASE;
   endfunction

   // Prefix, then random digits up to length-1, then a check digit that
   // makes the Luhn sum pass or fail as asked.
   function automatic logic [luhn_pkg::IN_WIDTH-1:0] build_card(input int prefix,
                                                                input int prefix_digits,
                                                                input int length,
                                                                input bit passing);
      logic [63:0] base;
      logic [63:0] cand;
      int          start;
      base = 64'(prefix);
      for (int i = prefix_digits; i < length - 1; i++) begin
         base = base * 64'(DECIMAL_BASE) + 64'($urandom_range(DECIMAL_BASE - 1));
      end
      start = $urandom_range(DECIMAL_BASE - 1);
      cand  = base * 64'(DECIMAL_BASE);
      for (int k = 0; k < DECIMAL_BASE; k++) begin
         cand = base * 64'(DECIMAL_BASE) + 64'((start + k) % DECIMAL_BASE);
         if ((luhn_residue(cand) == 0) == passing) return cand[luhn_pkg::IN_WIDTH-1:0];
      end
      return cand[luhn_pkg::IN_WIDTH-1:0];
   endfunction

   function automatic int brand_like_prefix();
      case ($urandom_range(2))
         0:       return $urandom_range(1) ? PREFIX_A_OTHER : PREFIX_A_FIRST;
         1:       return $urandom_range(PREFIX_B_MAX, PREFIX_B_MIN);
         default: return PREFIX_C_LEAD * DECIMAL_BASE + $urandom_range(DECIMAL_BASE - 1);
      endcase
   endfunction

   // Mostly well-formed cards of valid lengths, then odd lengths, then raw noise.
   function automatic logic [luhn_pkg::IN_WIDTH-1:0] random_card();
      int          pick;
      int          len;
      bit          passing;
      logic [63:0] raw;
      pick    = $urandom_range(99);
      passing = $urandom_range(99) < 80;
      if (pick < 65) begin
         case ($urandom_range(4))
            0: return build_card($urandom_range(1) ? PREFIX_A_OTHER : PREFIX_A_FIRST,
                                 2, 15, passing);
            1: return build_card($urandom_range(PREFIX_B_MAX, PREFIX_B_MIN), 2, 16, passing);
            2: return build_card(brand_like_prefix() % DECIMAL_BASE +
                                 PREFIX_C_LEAD * DECIMAL_BASE, 2,
                                 $urandom_range(1) ? 16 : 13, passing);
            3: begin
               case ($urandom_range(2))
                  0:       len = 13;
                  1:       len = 15;
                  default: len = 16;
               endcase
               return build_card($urandom_range(89, 10), 2, len, passing);
            end
            default: return build_card(brand_like_prefix(), 2, $urandom_range(19, 3), passing);
         endcase
      end else if (pick < 80) begin
         return build_card($urandom_range(8, 1), 1, $urandom_range(19, 2), passing);
      end
      raw = {$urandom, $urandom};
      raw = raw >> $urandom_range(62);
      return raw[luhn_pkg::IN_WIDTH-1:0];
   endfunction

   // Offer one card, idling first as the phase asks; return at the accepting edge.
   task automatic send_card(input logic [luhn_pkg::IN_WIDTH-1:0] number);
      int gaps;
      gaps = 0;
      while (gaps < MAX_GAP && $urandom_range(99) < send_idle_pct) gaps++;
      if (gaps != 0) begin
         req_valid <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_card_number <= number;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stop offering and hold until every predicted verdict has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Receiver: random stalls, plus one long hold-off counted here on request.
   initial begin : receiver
      int hold_served;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_request_id != hold_served) begin
            hold_served = hold_request_id;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: end the run when the channels go quiet for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int send_pcts [4];
      int stall_pcts [4];
      send_pcts  = '{0, 62, 0, 13};
      stall_pcts = '{0, 0, 62, 13};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, short numbers used as their own prefix, the top of
      // the range, every brand with a passing checksum (brand A also with a
      // failing one), and brand prefixes at the wrong length
      send_card(63'd0);
      send_card(63'd1);
      send_card(63'd4);
      send_card(63'd9);
      send_card(63'd10);
      send_card(63'd34);
      send_card(63'd37);
      send_card(63'd55);
      send_card(63'd99);
      send_card(63'd100);
      send_card(63'd400);
      send_card({luhn_pkg::IN_WIDTH{1'b1}});
      send_card(63'd1000000000000000000);
      send_card(63'd999999999999999999);
      send_card(build_card(PREFIX_A_FIRST, 2, 15, 1'b1));
      send_card(build_card(PREFIX_A_OTHER, 2, 15, 1'b1));
      send_card(build_card(PREFIX_A_FIRST, 2, 15, 1'b0));
      send_card(build_card(PREFIX_A_OTHER, 2, 16, 1'b1));
      send_card(build_card(PREFIX_B_MIN, 2, 16, 1'b1));
      send_card(build_card(PREFIX_B_MAX, 2, 16, 1'b1));
      send_card(build_card(PREFIX_B_MIN - 1, 2, 16, 1'b1));
      send_card(build_card(PREFIX_B_MAX + 1, 2, 16, 1'b1));
      send_card(build_card(PREFIX_C_LEAD, 1, 13, 1'b1));
      send_card(build_card(PREFIX_C_LEAD, 1, 16, 1'b1));
      send_card(build_card(PREFIX_C_LEAD, 1, 15, 1'b1));
      drain();

      // hold the response side for a long stretch while cards keep coming,
      // so the block fills and stalls its input
      hold_request_id++;
      for (int i = 0; i < HOLD_ITEMS; i++) send_card(random_card());
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = send_pcts[phase];
         recv_stall_pct = stall_pcts[phase];
         for (int i = 0; i < PHASE_ITEMS; i++) send_card(random_card());
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
